### rtl/fwbp_pkg.sv
package fwbp_pkg;

    localparam int MAX_WIDTH = 64;
    localparam int VALUE_W = 64;
    localparam int CFG_W = 7;
    localparam logic [CFG_W-1:0] BLOCK_SIZE_RESET = 7'd8;

    // Partial byte carried between items: right-aligned, earliest bit highest.
    typedef struct packed {
        logic [6:0] bits;
        logic [2:0] count;
    } pend_t;

endpackage

### rtl/fwbp_pack.sv
module fwbp_pack #(
    parameter int MaxWidth = fwbp_pkg::MAX_WIDTH,
    localparam int MaxBytes = (MaxWidth + 14) / 8,
    localparam int StreamW = 8 * MaxBytes,
    localparam int CntW = $clog2(MaxBytes + 1)
) (
    input  logic [fwbp_pkg::CFG_W-1:0]   block_size,
    input  fwbp_pkg::pend_t              pend,
    input  logic [fwbp_pkg::VALUE_W-1:0] value,
    input  logic                         last_value,
    output logic [StreamW-1:0]           stream,
    output logic [CntW-1:0]              nbytes,
    output fwbp_pkg::pend_t              pend_next
);

    logic [6:0]          width;
    logic [MaxWidth-1:0] val_l;
    logic [7:0]          pend8;
    logic [6:0]          total;
    logic [3:0]          nfull;
    logic [2:0]          rem;
    logic [7:0]          sel;

    always_comb
    begin
        if (block_size == '0)
        begin
            width = 7'd1;
        end
        else if (block_size > 7'(MaxWidth))
        begin
            width = 7'(MaxWidth);
        end
        else
        begin
            width = block_size;
        end

        // kept bits left-aligned, then placed after the carried partial byte
        val_l = value[MaxWidth-1:0] << (7'(MaxWidth) - width);
        pend8 = 8'({1'b0, pend.bits} << (4'd8 - {1'b0, pend.count}));
        stream = {pend8, {(StreamW - 8){1'b0}}}
               | ({val_l, {(StreamW - MaxWidth){1'b0}}} >> pend.count);

        total = 7'(pend.count) + width;
        nfull = total[6:3];
        rem = total[2:0];

        sel = '0;
        for (int b = 0; b < MaxBytes; b++)
        begin
            if (4'(b) == nfull)
            begin
                sel = stream[StreamW - 1 - 8 * b -: 8];
            end
        end

        nbytes = CntW'(nfull) + CntW'(last_value && (rem != 3'd0));

        if (last_value)
        begin
            pend_next.bits = '0;
            pend_next.count = '0;
        end
        else
        begin
            pend_next.bits = 7'(sel >> (4'd8 - {1'b0, rem}));
            pend_next.count = rem;
        end
    end

endmodule

### rtl/fwbp_emit.sv
module fwbp_emit #(
    parameter int MaxWidth = fwbp_pkg::MAX_WIDTH,
    localparam int MaxBytes = (MaxWidth + 14) / 8,
    localparam int StreamW = 8 * MaxBytes,
    localparam int CntW = $clog2(MaxBytes + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load_valid,
    input  logic [StreamW-1:0] stream,
    input  logic [CntW-1:0]    nbytes,
    input  logic               last,
    output logic               load_ready,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         out_byte,
    output logic               out_last
);

    logic [StreamW-1:0] stream_reg;
    logic [CntW-1:0]    cnt_reg;
    logic               last_reg;
    logic               take;

    assign out_valid = (cnt_reg != '0);
    assign take = out_valid && !out_stall;
    // free when empty or when the final byte leaves this cycle
    assign load_ready = (cnt_reg == '0) || ((cnt_reg == CntW'(1)) && take);
    assign out_byte = stream_reg[StreamW-1 -: 8];
    assign out_last = last_reg && (cnt_reg == CntW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (load_valid && load_ready)
        begin
            cnt_reg <= nbytes;
        end
        else if (take)
        begin
            cnt_reg <= cnt_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_valid && load_ready)
        begin
            stream_reg <= stream;
            last_reg <= last;
        end
        else if (take)
        begin
            stream_reg <= stream_reg << 8;
        end
    end

endmodule

### rtl/fixed_width_bit_packer_unit.sv
// Packs the low block_size bits of each signed value, msb first, into one
// continuous byte stream; an item with last_value set flushes the partial
// byte (zero padded) and flags the final byte with out_last. Items enter an
// input register, are packed in one pass into the byte register, and the
// bytes leave one per cycle while out_stall is low, so an item yields
// floor((carried bits + block_size) / 8) bytes, rounded up on a last item,
// at most 9, and the input takes one item per cycle while items yield at
// most one byte each and out_stall is low. The first byte is offered once
// the item reaches the byte register. block_size 0 acts as 1, values
// above MaxWidth act as MaxWidth; write it only while the block is idle.
module fixed_width_bit_packer_unit #(
    parameter int MaxWidth = fwbp_pkg::MAX_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [fwbp_pkg::VALUE_W-1:0] value,
    input  logic                                last_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [7:0]                          out_byte,
    output logic                                out_last,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fwbp_pkg::CFG_W-1:0]          block_size
);

    localparam int MaxBytes = (MaxWidth + 14) / 8;
    localparam int StreamW = 8 * MaxBytes;
    localparam int CntW = $clog2(MaxBytes + 1);

    logic [fwbp_pkg::CFG_W-1:0]   bs_reg;
    logic                         a_valid_reg;
    logic [fwbp_pkg::VALUE_W-1:0] value_reg;
    logic                         last_reg;
    fwbp_pkg::pend_t              pend_reg;
    fwbp_pkg::pend_t              pend_next;
    logic [StreamW-1:0]           stream;
    logic [CntW-1:0]              nbytes;
    logic                         emit_ready;
    logic                         a_move;
    logic                         in_take;

    assign cfg_ready = 1'b1;
    assign a_move = a_valid_reg && emit_ready;
    assign in_stall = a_valid_reg && !emit_ready;
    assign in_take = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bs_reg <= fwbp_pkg::BLOCK_SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            bs_reg <= block_size;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            pend_reg <= '0;
        end
        else
        begin
            if (in_take)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_move)
            begin
                a_valid_reg <= 1'b0;
            end
            if (a_move)
            begin
                pend_reg <= pend_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            value_reg <= value;
            last_reg <= last_value;
        end
    end

    fwbp_pack #(
        .MaxWidth(MaxWidth)
    ) u_pack (
        .block_size(bs_reg),
        .pend(pend_reg),
        .value(value_reg),
        .last_value(last_reg),
        .stream(stream),
        .nbytes(nbytes),
        .pend_next(pend_next)
    );

    fwbp_emit #(
        .MaxWidth(MaxWidth)
    ) u_emit (
        .clk(clk),
        .rst_n(rst_n),
        .load_valid(a_valid_reg),
        .stream(stream),
        .nbytes(nbytes),
        .last(last_reg),
        .load_ready(emit_ready),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_byte(out_byte),
        .out_last(out_last)
    );

`ifndef NO_ASSERTIONS
    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (a_move && last_reg) |=> (pend_reg.count == 3'd0 && pend_reg.bits == 7'd0))
        else $error("partial byte survived a final item");

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> a_valid_reg)
        else $error("input stalled with empty input register");

    a_last_on_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_last |-> out_valid)
        else $error("out_last without a byte");

    a_hold_output: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_byte) && $stable(out_last)))
        else $error("stalled byte changed");
`endif

endmodule

### tb/tb_top.sv
module tb_top;

    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_CYCLES = 16;
    localparam int QUIET_LIMIT  = 2000;

    typedef struct {
        logic [7:0] data;
        logic       is_end;
    } stream_byte_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                in_valid = 1'b0;
    logic                                in_stall;
    logic signed [fwbp_pkg::VALUE_W-1:0] value = '0;
    logic                                last_value = 1'b0;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic [7:0]                          out_byte;
    logic                                out_last;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [fwbp_pkg::CFG_W-1:0]          block_size = fwbp_pkg::BLOCK_SIZE_RESET;

    // Predictor state: configured width and the partial byte carried between items.
    logic [fwbp_pkg::CFG_W-1:0] width_setting = fwbp_pkg::BLOCK_SIZE_RESET;
    fwbp_pkg::pend_t            carry = '0;
    stream_byte_t               packed_stream_q[$];

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    logic long_hold = 1'b0;
    int  hold_count = 0;
    int  mismatch_count = 0;
    int  quiet_cycles = 0;

    fixed_width_bit_packer_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .last_value (last_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .out_last   (out_last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .block_size (block_size)
    );

    always #10 clk = ~clk;

    // Append the kept bits of one value to the expected byte stream.
    function automatic void pack_value(input logic [fwbp_pkg::VALUE_W-1:0] v,
                                       input logic is_last);
        int           width;
        int           i;
        int           cnt;
        int           produced;
        logic [7:0]   acc;
        stream_byte_t sb;
        if (width_setting == 0)
            width = 1;
        else if (width_setting > fwbp_pkg::MAX_WIDTH)
            width = fwbp_pkg::MAX_WIDTH;
        else
            width = int'(width_setting);
        acc = {1'b0, carry.bits};
        cnt = int'(carry.count);
        produced = 0;
        for (i = width - 1; i >= 0; i--)
        begin
            acc = {acc[6:0], v[i]};
            cnt++;
            if (cnt == 8)
            begin
                sb.data = acc;
                sb.is_end = 1'b0;
                packed_stream_q.push_back(sb);
                produced++;
                acc = '0;
                cnt = 0;
            end
        end
        if (is_last)
        begin
            if (cnt > 0)
            begin
                sb.data = acc << (8 - cnt);
                sb.is_end = 1'b1;
                packed_stream_q.push_back(sb);
            end
            else if (produced > 0)
            begin
                // stream ended on a byte boundary: flag the last full byte
                sb = packed_stream_q.pop_back();
                sb.is_end = 1'b1;
                packed_stream_q.push_back(sb);
            end
            acc = '0;
            cnt = 0;
        end
        carry.bits = acc[6:0];
        carry.count = cnt[2:0];
    endfunction

    task automatic flag_mismatch(input string what, input logic [7:0] exp_v,
                                 input logic [7:0] act_v);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch: %s expected %02h got %02h", what, exp_v, act_v);
    endtask

    // Output check
    always @(posedge clk)
    begin
        stream_byte_t sb;
        if (rst_n && out_valid && !out_stall)
        begin
            if (packed_stream_q.size() == 0)
                flag_mismatch("byte with nothing pending", 8'h00, out_byte);
            else
            begin
                sb = packed_stream_q.pop_front();
                if (out_byte !== sb.data)
                    flag_mismatch("out_byte", sb.data, out_byte);
                if (out_last !== sb.is_end)
                    flag_mismatch("out_last", {7'd0, sb.is_end}, {7'd0, out_last});
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (long_hold && hold_count < HOLD_CYCLES)
        begin
            out_stall <= 1'b1;
            hold_count <= hold_count + 1;
        end
        else
        begin
            if (!long_hold)
                hold_count <= 0;
            out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Sends one item; valid stays high after acceptance until the next gap.
    task automatic send_item(input logic [fwbp_pkg::VALUE_W-1:0] v, input logic is_last);
        if ($urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99, 0) < send_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        value <= v;
        last_value <= is_last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pack_value(v, is_last);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (packed_stream_q.size() != 0)
            @(posedge clk);
        // items that yield no byte may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_block_size(input logic [fwbp_pkg::CFG_W-1:0] bs);
        wait_idle();
        cfg_valid <= 1'b1;
        block_size <= bs;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        width_setting = bs;
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    function automatic logic [fwbp_pkg::VALUE_W-1:0] random_value();
        logic [fwbp_pkg::VALUE_W-1:0] v;
        logic [31:0]                  tmp;
        tmp = $urandom;
        case ($urandom_range(3, 0))
            0: v = {$urandom, $urandom};
            1: v = {59'd0, tmp[4:0]} - 64'd16;
            2:
            begin
                case (tmp[1:0])
                    2'd0: v = 64'h8000_0000_0000_0000;
                    2'd1: v = 64'h7FFF_FFFF_FFFF_FFFF;
                    2'd2: v = '0;
                    default: v = '1;
                endcase
            end
            default: v = {$urandom, $urandom} & {$urandom, $urandom};
        endcase
        return v;
    endfunction

    // Width 8 out of reset
    task automatic test_reset_width();
        set_idling(0, 0);
        send_item(64'hFFFF_FFFF_FFFF_FFA5, 1'b0);
        send_item(64'h0000_0000_0000_003C, 1'b1);
    endtask

    // Width 0 acts as 1; odd width with padding on last
    task automatic test_narrow_widths();
        set_block_size(7'd0);
        send_item(64'd1, 1'b0);
        send_item(64'd0, 1'b0);
        send_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        set_block_size(7'd3);
        send_item(64'd5, 1'b0);
        send_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_item(64'd0, 1'b0);
        send_item(64'd2, 1'b1);
        set_block_size(7'd4);
        send_item(64'hFFFF_FFFF_FFFF_FFF9, 1'b0);
        send_item(64'd6, 1'b1);
    endtask

    // Saturation above the maximum, full width, and a nine-byte item
    task automatic test_wide_widths();
        set_block_size(7'd127);
        send_item(64'h8000_0000_0000_0000, 1'b0);
        send_item(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
        set_block_size(7'd64);
        send_item(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
        set_block_size(7'd7);
        send_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        set_block_size(7'd64);
        send_item(64'h0123_4567_89AB_CDEF, 1'b1);
        set_block_size(7'd85);
        send_item(64'h5555_5555_5555_5555, 1'b1);
        set_block_size(7'd42);
        send_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    endtask

    task automatic test_random_streams();
        logic [fwbp_pkg::CFG_W-1:0] sizes[8];
        int                         p;
        int                         k;
        sizes = '{7'd1, 7'd64, 7'd7, 7'd127, 7'd0, 7'd13, 7'd33, 7'd8};
        for (p = 0; p < 8; p++)
        begin
            if (p == 7)
                sizes[p] = 7'($urandom_range(127, 0));
            set_block_size(sizes[p]);
            case (p % 4)
                0: set_idling(0, 0);
                1: set_idling(73, 0);
                2: set_idling(0, 73);
                default: set_idling(18, 18);
            endcase
            for (k = 0; k < 30; k++)
                send_item(random_value(), (k == 29) || ($urandom_range(5, 0) == 0));
        end
    endtask

    // Receiver holds off while the sender keeps offering full-width items
    task automatic test_backpressure();
        int k;
        set_block_size(7'd64);
        set_idling(0, 0);
        long_hold <= 1'b1;
        for (k = 0; k < 20; k++)
            send_item({$urandom, $urandom}, k == 19);
        wait_idle();
        long_hold <= 1'b0;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_width();
        test_narrow_widths();
        test_wide_widths();
        test_backpressure();
        test_random_streams();
        set_idling(0, 0);
        wait_idle();
        mismatch_count += packed_stream_q.size();
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### fixed_width_bit_packer_unit.f
rtl/fwbp_pkg.sv
rtl/fwbp_pack.sv
rtl/fwbp_emit.sv
rtl/fixed_width_bit_packer_unit.sv
tb/tb_top.sv
